// ----- hw/rtl/valid_kmer_counter_histogram_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the valid k-mer counter
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef VALID_KMER_COUNTER_HISTOGRAM_DEFINES_SVH
`define VALID_KMER_COUNTER_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VKCH_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vkch: assertion failed");
// next-cycle implication
`define VKCH_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vkch: assertion failed");
`else
`define VKCH_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define VKCH_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/vkch_pkg.sv -----
// ----------------------------------------------------------------------------
// vkch_pkg
// Shared types and constants of the valid k-mer counter.
// ----------------------------------------------------------------------------
package vkch_pkg;

    localparam int CNT_W      = 10;
    localparam int BIN_W      = 10;
    localparam int HIST_DEPTH = 1 << BIN_W;
    localparam int OUT_W      = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 112;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [CNT_W-1:0] KLEN_RESET = CNT_W'(31);
    localparam logic [CNT_W-1:0] MINK_RESET = '0;

    // input selector
    localparam logic MODE_CHAR  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // result kind
    localparam logic REPLY_READ  = 1'b0;
    localparam logic REPLY_QUERY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_KMER_LENGTH = 1'b0;
    localparam logic REG_MIN_KMERS   = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] kmer_length;
        logic [CNT_W-1:0] min_kmers;
    } cfg_t;

    // request from the scanner to the histogram stage
    typedef struct packed {
        logic             valid;
        logic             reply_kind;
        logic             bad_char;
        logic             bump;        // increment the bin and report it
        logic [BIN_W-1:0] addr;
        logic [CNT_W-1:0] kmer_count;
        logic             keep;
        logic [OUT_W-1:0] reads_total;
        logic [OUT_W-1:0] reads_kept;
    } hist_req_t;

    typedef struct packed {
        logic             valid;
        logic             reply_kind;
        logic [CNT_W-1:0] kmer_count;
        logic             keep;
        logic             bad_char;
        logic [OUT_W-1:0] bin_reads;
        logic [OUT_W-1:0] reads_total;
        logic [OUT_W-1:0] reads_kept;
    } result_t;

endpackage

// ----- hw/rtl/valid_kmer_counter_histogram.sv -----
// ----------------------------------------------------------------------------
// valid_kmer_counter_histogram
// Valid k-mer counter per DNA read, with read-count histogram and tallies.
// ----------------------------------------------------------------------------
// Feed one read character per item (tuser low); tlast marks the last
// character of a read. Each N-free run of length L >= k adds L-k+1 windows;
// lowercase n is a base. At read end one item comes out with the window
// count, the keep flag and the updated histogram bin and tallies. An item
// with tuser high is a query of one histogram bin plus the tallies. An
// invalid character latches an error until reset: later reads give error
// items and are not tallied. The block takes one item per clock while
// the output side is not stalled; an item's result passes the histogram
// stage register (memory read) and then the output register. After reset
// the histogram memory is swept clear one bin a cycle, all 1024 bins, while
// s_axis_tready stays low; configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
module valid_kmer_counter_histogram #(
    parameter int MAX_COUNT   = 1023,
    parameter int TALLY_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vkch_pkg::PADDR_W-1:0]      paddr,
    input  logic [vkch_pkg::PDATA_W-1:0]      pwdata,
    output logic [vkch_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [vkch_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // base_char[7:0], bin_index[17:8]
    input  logic                              s_axis_tuser,  // mode
    input  logic                              s_axis_tlast,  // end_of_read
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // kmer_count[9:0], keep[10], bad_char[11], bin_reads[43:12],
    // reads_total[75:44], reads_kept[107:76]
    output logic [vkch_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser   // reply_kind
);
    import vkch_pkg::*;

    cfg_t      cfg;
    hist_req_t req;
    result_t   res;
    result_t   out_reg;
    logic      out_valid_reg, out_valid_next;
    logic      accept;
    logic      out_free;
    logic      hist_ready;

    vkch_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // An item is taken whenever the histogram stage can move on.
    assign s_axis_tready = hist_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    vkch_scan #(
        .MAX_COUNT   (MAX_COUNT),
        .TALLY_WIDTH (TALLY_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (s_axis_tuser),
        .base_char   (s_axis_tdata[7:0]),
        .end_of_read (s_axis_tlast),
        .bin_index   (s_axis_tdata[17:8]),
        .cfg         (cfg),
        .req         (req)
    );

    vkch_hist #(
        .TALLY_WIDTH (TALLY_WIDTH)
    ) u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .ready    (hist_ready),
        .res      (res)
    );

    // Output register: free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the payload while the downstream side stalls
    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.reply_kind;
    assign m_axis_tdata  = {4'b0000, out_reg.reads_kept, out_reg.reads_total,
                            out_reg.bin_reads, out_reg.bad_char, out_reg.keep,
                            out_reg.kmer_count};

endmodule

// ----- hw/rtl/vkch_cfg.sv -----
// ----------------------------------------------------------------------------
// vkch_cfg
// APB register file: window length and minimum count.
// ----------------------------------------------------------------------------
module vkch_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vkch_pkg::PADDR_W-1:0]  paddr,
    input  logic [vkch_pkg::PDATA_W-1:0]  pwdata,
    output logic [vkch_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output vkch_pkg::cfg_t                cfg
);
    import vkch_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_KMER_LENGTH: cfg_next.kmer_length = pwdata[CNT_W-1:0];
                REG_MIN_KMERS:   cfg_next.min_kmers   = pwdata[CNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_KMER_LENGTH: prdata = PDATA_W'(cfg_reg.kmer_length);
            REG_MIN_KMERS:   prdata = PDATA_W'(cfg_reg.min_kmers);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kmer_length <= KLEN_RESET;
            cfg_reg.min_kmers   <= MINK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/vkch_scan.sv -----
// ----------------------------------------------------------------------------
// vkch_scan
// Per-character run tracking, error latch and read tallies.
// ----------------------------------------------------------------------------
`include "valid_kmer_counter_histogram_defines.svh"

module vkch_scan #(
    parameter int MAX_COUNT   = 1023,
    parameter int TALLY_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            mode,
    input  logic [7:0]                      base_char,
    input  logic                            end_of_read,
    input  logic [vkch_pkg::BIN_W-1:0]      bin_index,
    input  vkch_pkg::cfg_t                  cfg,
    output vkch_pkg::hist_req_t             req
);
    import vkch_pkg::*;

    localparam int RUN_CAP_I = (1 << CNT_W) - 1;
    localparam int CNT_CAP_I = (MAX_COUNT < RUN_CAP_I) ? MAX_COUNT : RUN_CAP_I;
    localparam logic [CNT_W-1:0] RUN_CAP = CNT_W'(RUN_CAP_I);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);

    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_UP_N = 8'h4E;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CASE_OFS = 8'h20;

    logic [CNT_W-1:0]       run_reg, run_next;
    logic [CNT_W-1:0]       kmers_reg, kmers_next;
    logic                   halted_reg, halted_next;
    logic [TALLY_WIDTH-1:0] total_reg, total_next;
    logic [TALLY_WIDTH-1:0] kept_reg, kept_next;

    logic [CNT_W-1:0]       k_eff;
    logic [7:0]             ch_lc;
    logic                   ch_ok;
    logic                   halted_after;
    logic [CNT_W-1:0]       run_inc;
    logic [CNT_W-1:0]       run_char;
    logic [CNT_W-1:0]       kmers_char;
    logic                   keep;
    logic [TALLY_WIDTH-1:0] total_inc;
    logic [TALLY_WIDTH-1:0] kept_inc;
    logic                   tally_now;

    always_comb
    begin
        // zero window length acts as one
        k_eff = (cfg.kmer_length == '0) ? CNT_W'(1) : cfg.kmer_length;
        ch_lc = ((base_char >= CH_UP_A) && (base_char <= CH_UP_Z)) ?
                (base_char + CASE_OFS) : base_char;
        ch_ok = (ch_lc == CH_A) || (ch_lc == CH_C) || (ch_lc == CH_G) ||
                (ch_lc == CH_T) || (ch_lc == CH_N);
        halted_after = halted_reg || !ch_ok;
        run_inc = (run_reg == RUN_CAP) ? run_reg : run_reg + CNT_W'(1);

        run_char   = run_reg;
        kmers_char = kmers_reg;
        if (!halted_after)
        begin
            if (base_char == CH_UP_N)
            begin
                run_char = '0;
            end
            else
            begin
                run_char = run_inc;
                if ((run_inc >= k_eff) && (kmers_reg < CNT_CAP))
                begin
                    kmers_char = kmers_reg + CNT_W'(1);
                end
            end
        end

        keep      = kmers_char >= cfg.min_kmers;
        total_inc = (&total_reg) ? total_reg : total_reg + 1'b1;
        kept_inc  = (&kept_reg) ? kept_reg : kept_reg + 1'b1;
        tally_now = accept && (mode == MODE_CHAR) && end_of_read && !halted_after;

        run_next    = run_reg;
        kmers_next  = kmers_reg;
        halted_next = halted_reg;
        total_next  = total_reg;
        kept_next   = kept_reg;
        if (accept && (mode == MODE_CHAR))
        begin
            halted_next = halted_after;
            run_next    = end_of_read ? '0 : run_char;
            kmers_next  = end_of_read ? '0 : kmers_char;
        end
        if (tally_now)
        begin
            total_next = total_inc;
            if (keep)
            begin
                kept_next = kept_inc;
            end
        end

        // request to the histogram stage
        req             = '0;
        req.valid       = accept && ((mode == MODE_QUERY) || end_of_read);
        req.reply_kind  = (mode == MODE_QUERY) ? REPLY_QUERY : REPLY_READ;
        req.reads_total = OUT_W'(total_reg);
        req.reads_kept  = OUT_W'(kept_reg);
        if (mode == MODE_QUERY)
        begin
            req.bad_char = halted_reg;
            req.addr     = bin_index;
        end
        else if (halted_after)
        begin
            req.bad_char = 1'b1;
        end
        else
        begin
            req.bump        = 1'b1;
            req.addr        = BIN_W'(kmers_char);
            req.kmer_count  = kmers_char;
            req.keep        = keep;
            req.reads_total = OUT_W'(total_inc);
            req.reads_kept  = keep ? OUT_W'(kept_inc) : OUT_W'(kept_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= '0;
            kmers_reg  <= '0;
            halted_reg <= 1'b0;
            total_reg  <= '0;
            kept_reg   <= '0;
        end
        else
        begin
            run_reg    <= run_next;
            kmers_reg  <= kmers_next;
            halted_reg <= halted_next;
            total_reg  <= total_next;
            kept_reg   <= kept_next;
        end
    end

    `VKCH_ASSERT_NXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg)
    `VKCH_ASSERT_IMP(a_kmers_capped, clk, rst_n, 1'b1, kmers_reg <= CNT_CAP)
    `VKCH_ASSERT_IMP(a_kept_le_total, clk, rst_n, 1'b1, kept_reg <= total_reg)

endmodule

// ----- hw/rtl/vkch_hist.sv -----
// ----------------------------------------------------------------------------
// vkch_hist
// Histogram memory: clearing sweep, read-modify-write with forwarding.
// ----------------------------------------------------------------------------
`include "valid_kmer_counter_histogram_defines.svh"

module vkch_hist #(
    parameter int TALLY_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vkch_pkg::hist_req_t   req,
    input  logic                  out_free,
    output logic                  ready,
    output vkch_pkg::result_t     res
);
    import vkch_pkg::*;

    logic [TALLY_WIDTH-1:0] hist_mem [HIST_DEPTH];
    logic [TALLY_WIDTH-1:0] rdata_reg;

    hist_req_t              s1_reg;
    logic                   clr_active_reg;
    logic [BIN_W-1:0]       clr_addr_reg;
    logic                   fwd_valid_reg;
    logic [BIN_W-1:0]       fwd_addr_reg;
    logic [TALLY_WIDTH-1:0] fwd_data_reg;

    logic                   rd_en;
    logic                   advance;
    logic [TALLY_WIDTH-1:0] cur_val;
    logic [TALLY_WIDTH-1:0] inc_val;
    logic                   we;
    logic [BIN_W-1:0]       wa;
    logic [TALLY_WIDTH-1:0] wd;

    always_comb
    begin
        ready   = !clr_active_reg && (!s1_reg.valid || out_free);
        advance = s1_reg.valid && out_free;
        rd_en   = req.valid && ((req.reply_kind == REPLY_QUERY) || req.bump);
        // the latest write may have hit this entry at or after its read
        cur_val = (fwd_valid_reg && (fwd_addr_reg == s1_reg.addr)) ? fwd_data_reg : rdata_reg;
        inc_val = (&cur_val) ? cur_val : cur_val + 1'b1;
        we      = clr_active_reg || (advance && s1_reg.bump);
        wa      = clr_active_reg ? clr_addr_reg : s1_reg.addr;
        wd      = clr_active_reg ? '0 : inc_val;

        res             = '0;
        res.valid       = s1_reg.valid;
        res.reply_kind  = s1_reg.reply_kind;
        res.kmer_count  = s1_reg.kmer_count;
        res.keep        = s1_reg.keep;
        res.bad_char    = s1_reg.bad_char;
        res.reads_total = s1_reg.reads_total;
        res.reads_kept  = s1_reg.reads_kept;
        if (s1_reg.bump)
        begin
            res.bin_reads = OUT_W'(inc_val);
        end
        else if (s1_reg.reply_kind == REPLY_QUERY)
        begin
            res.bin_reads = OUT_W'(cur_val);
        end
    end

    // memory port: read registered, read-before-write on the same entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rdata_reg <= hist_mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg         <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fwd_valid_reg  <= 1'b0;
            fwd_addr_reg   <= '0;
            fwd_data_reg   <= '0;
        end
        else
        begin
            if (!s1_reg.valid || out_free)
            begin
                s1_reg <= req;
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + BIN_W'(1);
                if (&clr_addr_reg)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (we)
            begin
                fwd_valid_reg <= 1'b1;
                fwd_addr_reg  <= wa;
                fwd_data_reg  <= wd;
            end
        end
    end

    `VKCH_ASSERT_IMP(a_no_take_in_clear, clk, rst_n, clr_active_reg, !ready)
    `VKCH_ASSERT_IMP(a_empty_in_clear, clk, rst_n, clr_active_reg, !s1_reg.valid)
    `VKCH_ASSERT_NXT(a_stall_holds, clk, rst_n, s1_reg.valid && !out_free, s1_reg.valid && $stable(s1_reg.addr))

endmodule

// ----- bench/valid_kmer_counter_histogram_test.sv -----
// ----------------------------------------------------------------------------
// valid_kmer_counter_histogram_test
// Streams DNA reads and histogram queries through the k-mer counter, predicts
// every result item from a behavioural copy of the counter, histogram and
// tallies, and compares each result field by field under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module valid_kmer_counter_histogram_test;

    import vkch_pkg::*;

    localparam int MAX_COUNT   = 1023;
    localparam int RUN_CAP     = 1023;
    localparam int COUNT_CAP   = (MAX_COUNT < RUN_CAP) ? MAX_COUNT : RUN_CAP;
    localparam int QUIET_LIMIT = 3000;   // covers the clearing sweep of all 1024 bins
    localparam int SETTLE      = 4;      // histogram stage and output register plus margin
    localparam int RANDOM_ITEMS = 1000;

    // characters the counter recognises
    localparam logic [7:0] CH_UPPER_N = "N";
    localparam logic [7:0] CH_A       = "a";
    localparam logic [7:0] CH_C       = "c";
    localparam logic [7:0] CH_G       = "g";
    localparam logic [7:0] CH_T       = "t";
    localparam logic [7:0] CH_N       = "n";
    localparam logic [7:0] CH_BAD     = "@";

    typedef struct packed {
        logic             reply_kind;
        logic [CNT_W-1:0] kmer_count;
        logic             keep;
        logic             bad_char;
        logic [OUT_W-1:0] bin_reads;
        logic [OUT_W-1:0] reads_total;
        logic [OUT_W-1:0] reads_kept;
    } reply_t;

    // ------------------------------------------------------------------------
    // Behavioural copy of the counter: window count of the current read, the
    // error latch, the histogram of counts and the read tallies. Each accepted
    // input item may queue one expected reply.
    // ------------------------------------------------------------------------
    class kmer_tally;
        logic [CNT_W-1:0] klen;
        logic [CNT_W-1:0] mink;
        int               run_len;
        int               read_cnt;
        logic             halted;
        logic [OUT_W-1:0] hist [HIST_DEPTH];
        logic [OUT_W-1:0] total;
        logic [OUT_W-1:0] kept;
        reply_t           due_replies [$];
        int               errors;

        function new();
            klen     = KLEN_RESET;
            mink     = MINK_RESET;
            run_len  = 0;
            read_cnt = 0;
            halted   = 1'b0;
            total    = '0;
            kept     = '0;
            errors   = 0;
            foreach (hist[i])
                hist[i] = '0;
        endfunction

        function void set_reg(logic idx, logic [CNT_W-1:0] val);
            if (idx == REG_KMER_LENGTH)
                klen = val;
            else
                mink = val;
        endfunction

        static function logic [OUT_W-1:0] bump(logic [OUT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        static function bit base_ok(logic [7:0] ch);
            logic [7:0] low;
            low = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
            return low == CH_A || low == CH_C || low == CH_G || low == CH_T || low == CH_N;
        endfunction

        function void take_item(logic mode, logic [7:0] ch, logic last, logic [BIN_W-1:0] bin);
            reply_t r;
            int     k;
            k = (klen == 0) ? 1 : int'(klen);
            if (mode == MODE_QUERY) begin
                r = '{REPLY_QUERY, '0, 1'b0, halted, hist[bin], total, kept};
                due_replies = {due_replies, r};
                return;
            end
            if (!halted) begin
                if (!base_ok(ch))
                    halted = 1'b1;
                else if (ch == CH_UPPER_N)
                    run_len = 0;
                else begin
                    if (run_len < RUN_CAP)
                        run_len++;
                    if (run_len >= k && read_cnt < COUNT_CAP)
                        read_cnt++;
                end
            end
            if (!last)
                return;
            if (halted)
                r = '{REPLY_READ, '0, 1'b0, 1'b1, '0, total, kept};
            else begin
                r.reply_kind = REPLY_READ;
                r.kmer_count = CNT_W'(read_cnt);
                r.keep       = (CNT_W'(read_cnt) >= mink);
                r.bad_char   = 1'b0;
                hist[read_cnt] = bump(hist[read_cnt]);
                total = bump(total);
                if (r.keep)
                    kept = bump(kept);
                r.bin_reads   = hist[read_cnt];
                r.reads_total = total;
                r.reads_kept  = kept;
            end
            due_replies = {due_replies, r};
            run_len  = 0;
            read_cnt = 0;
        endfunction

        function void compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_reply(logic [OUT_DATA_W-1:0] d, logic kind);
            reply_t want;
            if (due_replies.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual tuser %0b tdata %h", $time, kind, d);
                return;
            end
            want = due_replies.pop_front();
            compare_field("reply_kind", want.reply_kind, kind);
            compare_field("kmer_count", want.kmer_count, d[9:0]);
            compare_field("keep", want.keep, d[10]);
            compare_field("bad_char", want.bad_char, d[11]);
            compare_field("bin_reads", want.bin_reads, d[43:12]);
            compare_field("reads_total", want.reads_total, d[75:44]);
            compare_field("reads_kept", want.reads_kept, d[107:76]);
        endfunction

        function int outstanding();
            return due_replies.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // base_char[7:0], bin_index[17:8]
    logic                  s_axis_tuser;   // mode
    logic                  s_axis_tlast;   // end_of_read
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // kmer_count[9:0], keep[10], bad_char[11], bin_reads[43:12],
    // reads_total[75:44], reads_kept[107:76]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;   // reply_kind

    kmer_tally tally;
    bit        gaps_on;
    bit        stalls_on;
    int        items_sent;
    int        quiet_cycles;

    valid_kmer_counter_histogram #(
        .MAX_COUNT   (MAX_COUNT),
        .TALLY_WIDTH (32)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Result side: stall in random bursts while allowed, otherwise hold ready.
    // ------------------------------------------------------------------------
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Sample accepted results at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tally.check_reply(m_axis_tdata, m_axis_tuser);
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    task automatic reg_check(input logic idx, input logic [CNT_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(want))
        begin
            tally.errors++;
            $display("%0t: register %0d expected %0h actual %0h", $time, idx, want, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(input logic idx, input logic [CNT_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tally.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_check(idx, val);
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Present one item and hold it until taken; leave tvalid high afterwards
    // so that back-to-back items need no extra assignment in the same step.
    task automatic push_item(input logic mode, input logic [7:0] ch, input logic last,
                             input logic [BIN_W-1:0] bin);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, bin, ch};
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        tally.take_item(mode, ch, last, bin);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(MODE_CHAR, s[i], i == s.len() - 1, BIN_W'($urandom));
    endtask

    task automatic send_query(input logic [BIN_W-1:0] bin);
        push_item(MODE_QUERY, 8'($urandom), 1'($urandom), bin);
    endtask

    function automatic logic [7:0] pick_base(input int n_pct);
        if ($urandom_range(0, 99) < n_pct)
            return CH_UPPER_N;
        case ($urandom_range(0, 8))
            0: return CH_A;
            1: return CH_C;
            2: return CH_G;
            3: return CH_T;
            4: return CH_N;
            5: return "A";
            6: return "C";
            7: return "G";
            default: return "T";
        endcase
    endfunction

    task automatic send_read(input int len, input int n_pct);
        for (int i = 0; i < len; i++)
            push_item(MODE_CHAR, pick_base(n_pct), i == len - 1, BIN_W'($urandom));
    endtask

    // Drop tvalid, wait for every expected result, then let the pipeline empty
    // of items that give no result.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tally.outstanding() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int               phase;
        int               phase_start;
        int               random_start;
        logic [CNT_W-1:0] k_val;
        logic [CNT_W-1:0] m_val;

        tally         = new();
        gaps_on       = 1'b0;
        stalls_on     = 1'b0;
        items_sent    = 0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_CHAR;
        s_axis_tlast  = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers come up at their reset values; write them during the sweep.
        reg_check(REG_KMER_LENGTH, KLEN_RESET);
        reg_check(REG_MIN_KMERS, MINK_RESET);
        reg_write(REG_KMER_LENGTH, 10'd2);
        reg_write(REG_MIN_KMERS, 10'd2);

        // Directed: empty bins, mixed case, lowercase n as a base, N splitting
        // runs, reads shorter than the window, then the touched bins.
        send_query('0);
        send_query('1);
        send_text("ACGT");
        send_text("acgtn");
        send_text("AcNgT");
        send_text("N");
        send_text("a");
        send_text("NNgg");
        send_query(10'd2);
        send_query(10'd0);
        drain();

        // Random phases under random settings, window length zero among them.
        phase        = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case (phase)
                0: begin k_val = 10'd0;    m_val = 10'd0;    end
                1: begin k_val = 10'd1;    m_val = 10'd1023; end
                2: begin k_val = 10'd1023; m_val = 10'd0;    end
                3: begin k_val = 10'd3;    m_val = 10'd5;    end
                default:
                begin
                    k_val = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(13, 1023))
                                                        : CNT_W'($urandom_range(1, 12));
                    m_val = CNT_W'($urandom_range(0, 25));
                end
            endcase
            reg_write(REG_KMER_LENGTH, k_val);
            reg_write(REG_MIN_KMERS, m_val);
            gaps_on     = ($urandom_range(0, 3) != 0);
            stalls_on   = ($urandom_range(0, 3) != 0);
            phase_start = items_sent;
            while (items_sent - phase_start < 100)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_query($urandom_range(0, 1) ? BIN_W'($urandom) : BIN_W'($urandom_range(0, 40)));
                else
                    send_read($urandom_range(0, 5) == 0 ? $urandom_range(26, 60)
                                                        : $urandom_range(1, 25),
                              ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 25));
            end
            drain();
            phase++;
        end

        // Last part, no idling: halt on an end-marked invalid character, then
        // reads of arbitrary bytes and queries while the error stays latched.
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        // let any stall burst still running finish
        repeat (8) @(negedge clk);
        send_text("ac");
        push_item(MODE_CHAR, CH_BAD, 1'b1, '0);
        send_query('1);
        push_item(MODE_CHAR, 8'h00, 1'b0, '0);
        push_item(MODE_CHAR, 8'hFF, 1'b1, '1);
        send_text("ACGTACGT");
        for (int r = 0; r < 12; r++)
        begin
            for (int i = 0; i < 4; i++)
                push_item(MODE_CHAR, 8'($urandom), i == 3, BIN_W'($urandom));
            send_query(BIN_W'($urandom));
        end

        drain();
        repeat (8) @(posedge clk);
        if (tally.errors == 0 && tally.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/vkch_pkg.sv
hw/rtl/vkch_cfg.sv
hw/rtl/vkch_scan.sv
hw/rtl/vkch_hist.sv
hw/rtl/valid_kmer_counter_histogram.sv
bench/valid_kmer_counter_histogram_test.sv
